// ----- rtl/rsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the reservation station dispatch block.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int ENTRIES_DEF       = 8;
  localparam int UNITS_DEF         = 4;
  localparam int OPERAND_WIDTH_DEF = 32;

  localparam int MODE_W  = 2;
  localparam int ENTRY_W = 3;
  localparam int UNIT_W  = 2;
  localparam int VALUE_W = 32;
  localparam int STALL_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE    = 2'd0,
    MODE_AVAIL    = 2'd1,
    MODE_DISPATCH = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [ENTRY_W-1:0]   entry;
    logic                 entry_in_use;
    logic                 entry_started;
    logic                 ready_first;
    logic                 ready_second;
    logic [UNIT_W-1:0]    unit;
    logic [VALUE_W-1:0]   operand_first;
    logic [VALUE_W-1:0]   operand_second;
    logic                 unit_free;
  } item_t;

  typedef struct packed {
    logic                 dispatched;
    logic [UNIT_W-1:0]    target_unit;
    logic [ENTRY_W-1:0]   tag;
    logic [VALUE_W-1:0]   value_first;
    logic [VALUE_W-1:0]   value_second;
    logic [STALL_W-1:0]   stall_count;
  } result_t;

  // Per-entry control bits kept next to the operands in the entry memory.
  typedef struct packed {
    logic                 ready_first;
    logic                 ready_second;
    logic [UNIT_W-1:0]    unit;
  } slot_ctrl_t;

  // Request to the stall counter unit: which unit, and whether to count.
  typedef struct packed {
    logic                 inc;
    logic [UNIT_W-1:0]    unit;
  } stall_req_t;

endpackage

// ----- rtl/rsd_entry_mem.sv -----
// ----------------------------------------------------------------------------
// rsd_entry_mem
// Entry memory holding ready flags, unit and operands of each entry.
// ----------------------------------------------------------------------------
module rsd_entry_mem
  import rsd_pkg::*;
#(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
  localparam int IW           = $clog2(ENTRIES)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [IW-1:0]            wr_addr,
  input  slot_ctrl_t               wr_ctrl,
  input  logic [OPERAND_WIDTH-1:0] wr_first,
  input  logic [OPERAND_WIDTH-1:0] wr_second,
  input  logic                     rd_en,
  input  logic [IW-1:0]            rd_addr,
  output slot_ctrl_t               rd_ctrl,
  output logic [OPERAND_WIDTH-1:0] rd_first,
  output logic [OPERAND_WIDTH-1:0] rd_second
);

  slot_ctrl_t               mem_ctrl   [ENTRIES];
  logic [OPERAND_WIDTH-1:0] mem_first  [ENTRIES];
  logic [OPERAND_WIDTH-1:0] mem_second [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ctrl[wr_addr]   <= wr_ctrl;
      mem_first[wr_addr]  <= wr_first;
      mem_second[wr_addr] <= wr_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ctrl   <= mem_ctrl[rd_addr];
      rd_first  <= mem_first[rd_addr];
      rd_second <= mem_second[rd_addr];
    end
  end

endmodule

// ----- rtl/rsd_stall_unit.sv -----
// ----------------------------------------------------------------------------
// rsd_stall_unit
// Per-unit saturating stall counters with one shared incrementer.
// ----------------------------------------------------------------------------
module rsd_stall_unit
  import rsd_pkg::*;
#(
  parameter int UNITS = UNITS_DEF,
  localparam int UW   = (UNITS > 1) ? $clog2(UNITS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  stall_req_t         req,
  output logic [STALL_W-1:0] count
);

  logic [STALL_W-1:0] counters [UNITS];
  logic               in_range;

  // Units beyond the configured count read as zero and never count.
  assign in_range = 32'(req.unit) < UNITS;
  assign count    = in_range ? counters[UW'(req.unit)] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < UNITS; i++) begin
        counters[i] <= '0;
      end
    end else if (req.inc && in_range && (count != '1)) begin
      counters[UW'(req.unit)] <= count + STALL_W'(1);
    end
  end

endmodule

// ----- rtl/reservation_station_dispatch_unit.sv -----
// ----------------------------------------------------------------------------
// reservation_station_dispatch_unit
// Reservation station with entry writes, unit availability, a one-entry-per-
// cycle dispatch scan and saturating per-unit stall counters.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                  Payload   Moves
//   -------  -------------------------  --------  ---------------------------
//   item     item_valid / item_stall    item_t    one command transaction
//   result   result_valid / result_stall result_t one result transaction
//
// Every accepted transaction produces exactly one result transaction.
// A dispatch scans the table: the entry memory has one read port, so the
// scan examines one entry per cycle, in the cycle after the read it issued,
// and stops at the first entry that dispatches or once every entry is read.
// Reset (rst, synchronous) clears all entries, unit flags, stall counters and
// the scan start; no clearing pass is needed since entry valid bits are flops.
// item_stall is high while a transaction is in work; a stalled result is held
// in the output register and a finished transaction waits in ST_DONE behind it.
//
module reservation_station_dispatch_unit
  import rsd_pkg::*;
#(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int UNITS         = UNITS_DEF,
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                   state;
  item_t                    cur;
  result_t                  res;
  logic [IW-1:0]            scan_start;
  logic [CW-1:0]            issue_cnt;
  logic                     rd_valid;
  logic [IW-1:0]            rd_idx;
  logic [ENTRIES-1:0]       used;
  logic [ENTRIES-1:0]       started;
  logic [UNITS-1:0]         available;

  logic                     issuing;
  logic                     rd_en;
  logic [IW:0]              idx_sum;
  logic [IW-1:0]            idx;
  logic [IW-1:0]            scan_next;
  slot_ctrl_t               rd_ctrl;
  logic [OPERAND_WIDTH-1:0] rd_first;
  logic [OPERAND_WIDTH-1:0] rd_second;
  logic                     cand;
  logic                     free;
  logic                     hit;
  logic                     done_fire;
  logic                     entry_ok;
  logic                     wr_en;
  slot_ctrl_t               wr_ctrl;
  stall_req_t               stall_req;
  logic [STALL_W-1:0]       stall_count;
  result_t                  done_res;

  // The block takes a new transaction only when nothing is in work.
  assign item_stall = (state != ST_IDLE);

  // Scan index: scan start plus the number of reads issued, wrapped once.
  assign issuing = (state == ST_SCAN) && (issue_cnt < CW'(ENTRIES));
  assign idx_sum = {1'b0, scan_start} + (IW + 1)'(issue_cnt);
  assign idx     = (idx_sum >= (IW + 1)'(ENTRIES)) ?
                   IW'(idx_sum - (IW + 1)'(ENTRIES)) : IW'(idx_sum);
  assign scan_next = (32'(scan_start) == ENTRIES - 1) ? '0 : scan_start + IW'(1);

  // Examine the entry read in the previous cycle.
  assign cand = rd_valid && used[rd_idx] && !started[rd_idx] &&
                rd_ctrl.ready_first && rd_ctrl.ready_second;
  assign free = (32'(rd_ctrl.unit) < UNITS) && available[UW'(rd_ctrl.unit)];
  assign hit  = (state == ST_SCAN) && cand && free;
  assign rd_en = issuing && !hit;

  // A ready entry whose unit is busy counts one stall for that unit. Outside
  // the scan the counter port serves the counter read of the current command.
  always_comb begin
    stall_req.inc  = (state == ST_SCAN) && cand && !free;
    stall_req.unit = (state == ST_SCAN) ? rd_ctrl.unit : cur.unit;
  end

  assign entry_ok  = 32'(cur.entry) < ENTRIES;
  assign done_fire = (state == ST_DONE) && (!result_valid || !result_stall);
  assign wr_en     = done_fire && (cur.mode == MODE_WRITE) && entry_ok;

  always_comb begin
    wr_ctrl.ready_first  = cur.ready_first;
    wr_ctrl.ready_second = cur.ready_second;
    wr_ctrl.unit         = cur.unit;
  end

  // Final result of the current command.
  always_comb begin
    done_res = '0;
    case (cur.mode)
      MODE_DISPATCH: done_res = res;
      MODE_READ:     done_res.stall_count = stall_count;
      default:       done_res = '0;
    endcase
  end

  rsd_entry_mem #(
    .ENTRIES       (ENTRIES),
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (IW'(cur.entry)),
    .wr_ctrl   (wr_ctrl),
    .wr_first  (OPERAND_WIDTH'(cur.operand_first)),
    .wr_second (OPERAND_WIDTH'(cur.operand_second)),
    .rd_en     (rd_en),
    .rd_addr   (idx),
    .rd_ctrl   (rd_ctrl),
    .rd_first  (rd_first),
    .rd_second (rd_second)
  );

  rsd_stall_unit #(
    .UNITS (UNITS)
  ) u_stall (
    .clk   (clk),
    .rst   (rst),
    .req   (stall_req),
    .count (stall_count)
  );

  // Sequencer, scan bookkeeping and entry flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_start <= '0;
      issue_cnt  <= '0;
      rd_valid   <= 1'b0;
      used       <= '0;
      started    <= '0;
      available  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            issue_cnt <= '0;
            rd_valid  <= 1'b0;
            if (item.mode == MODE_DISPATCH) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          rd_valid <= rd_en;
          if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (hit) begin
            started[rd_idx] <= 1'b1;
            scan_start      <= scan_next;
            state           <= ST_DONE;
          end else if (!issuing && !rd_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_fire) begin
            state <= ST_IDLE;
            if (wr_en) begin
              used[IW'(cur.entry)]    <= cur.entry_in_use;
              started[IW'(cur.entry)] <= cur.entry_started;
            end
            if ((cur.mode == MODE_AVAIL) && (32'(cur.unit) < UNITS)) begin
              available[UW'(cur.unit)] <= cur.unit_free;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: the command in work and the dispatch result.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && item_valid) begin
      cur <= item;
      res <= '0;
    end else if (hit) begin
      res.dispatched   <= 1'b1;
      res.target_unit  <= rd_ctrl.unit;
      res.tag          <= ENTRY_W'(rd_idx);
      res.value_first  <= VALUE_W'(rd_first);
      res.value_second <= VALUE_W'(rd_second);
    end
    if (rd_en) begin
      rd_idx <= idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      result <= done_res;
    end
  end

  // The scan never issues more reads than there are entries.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= CW'(ENTRIES))
    else $error("scan issued more reads than entries");

  // A dispatch moves the scan start on by exactly one place.
  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    hit |=> (scan_start == $past(scan_next)))
    else $error("scan start did not advance after dispatch");

  // The dispatched entry is marked started and the sequencer finishes.
  a_mark_started: assert property (@(posedge clk) disable iff (rst)
    hit |=> (started[$past(rd_idx)] && (state == ST_DONE)))
    else $error("dispatched entry not marked started");

  // Only a dispatch command ever runs the scan.
  a_scan_mode: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cur.mode == MODE_DISPATCH))
    else $error("scan running for a non-dispatch command");

endmodule

// ----- verif/rsd_checker.sv -----
// ----------------------------------------------------------------------------
// rsd_checker
// Passive checker for the reservation station dispatch block. It keeps its own
// copy of the station state, predicts the result of every accepted command
// transaction and compares each accepted result transaction, in order, field
// by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module rsd_checker
  import rsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      mismatches,
  output int      awaiting
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int UNITS   = UNITS_DEF;
  localparam int REPORT_LIMIT = 10;

  // Mirror of the station state.
  logic                slot_busy    [ENTRIES];
  logic                slot_issued  [ENTRIES];
  logic                slot_rdy_a   [ENTRIES];
  logic                slot_rdy_b   [ENTRIES];
  logic [UNIT_W-1:0]   slot_fu      [ENTRIES];
  logic [VALUE_W-1:0]  slot_opnd_a  [ENTRIES];
  logic [VALUE_W-1:0]  slot_opnd_b  [ENTRIES];
  logic                fu_free      [UNITS];
  logic [STALL_W-1:0]  fu_stalls    [UNITS];
  logic [ENTRY_W-1:0]  scan_head;

  result_t predicted_results[$];

  task automatic clear_station();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_busy[i]   = 1'b0;
      slot_issued[i] = 1'b0;
      slot_rdy_a[i]  = 1'b0;
      slot_rdy_b[i]  = 1'b0;
      slot_fu[i]     = '0;
      slot_opnd_a[i] = '0;
      slot_opnd_b[i] = '0;
    end
    for (int u = 0; u < UNITS; u++) begin
      fu_free[u]   = 1'b0;
      fu_stalls[u] = '0;
    end
    scan_head = '0;
  endtask

  // Applies one command to the mirrored state and returns the result it causes.
  // With four units and a two-bit unit field every unit index is in range.
  function automatic result_t station_step(input item_t cmd);
    result_t             res;
    logic [ENTRY_W-1:0]  idx;
    logic [UNIT_W-1:0]   fu;
    bit                  found;
    res   = '0;
    found = 1'b0;
    case (cmd.mode)
      MODE_WRITE: begin
        slot_busy[cmd.entry]   = cmd.entry_in_use;
        slot_issued[cmd.entry] = cmd.entry_started;
        slot_rdy_a[cmd.entry]  = cmd.ready_first;
        slot_rdy_b[cmd.entry]  = cmd.ready_second;
        slot_fu[cmd.entry]     = cmd.unit;
        slot_opnd_a[cmd.entry] = cmd.operand_first;
        slot_opnd_b[cmd.entry] = cmd.operand_second;
      end
      MODE_AVAIL: begin
        fu_free[cmd.unit] = cmd.unit_free;
      end
      MODE_READ: begin
        res.stall_count = fu_stalls[cmd.unit];
      end
      default: begin
        for (int k = 0; k < ENTRIES; k++) begin
          idx = scan_head + ENTRY_W'(k);
          if (!found && slot_busy[idx] && !slot_issued[idx] &&
              slot_rdy_a[idx] && slot_rdy_b[idx]) begin
            fu = slot_fu[idx];
            if (fu_free[fu]) begin
              found            = 1'b1;
              slot_issued[idx] = 1'b1;
              res.dispatched   = 1'b1;
              res.target_unit  = fu;
              res.tag          = idx;
              res.value_first  = slot_opnd_a[idx];
              res.value_second = slot_opnd_b[idx];
              scan_head        = scan_head + 1'b1;
            end else if (fu_stalls[fu] != '1) begin
              fu_stalls[fu] = fu_stalls[fu] + 1'b1;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] result %s mismatch: expected 0x%0h, got 0x%0h",
                 $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_station();
      predicted_results.delete();
      awaiting <= 0;
    end else begin
      if (item_valid && !item_stall)
        predicted_results.push_back(station_step(item));
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] unexpected result transaction: %p", $realtime, result);
        end else begin
          want = predicted_results.pop_front();
          check_field("dispatched",   32'(want.dispatched),  32'(result.dispatched));
          check_field("target_unit",  32'(want.target_unit), 32'(result.target_unit));
          check_field("tag",          32'(want.tag),         32'(result.tag));
          check_field("value_first",  want.value_first,  result.value_first);
          check_field("value_second", want.value_second, result.value_second);
          check_field("stall_count",  want.stall_count,  result.stall_count);
        end
      end
      awaiting <= predicted_results.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for reservation_station_dispatch_unit. A short directed sequence
// walks through stalls on busy units, skipped entries and the rotating scan
// start, then constrained-by-hand random traffic fills, dispatches and probes
// the station under three idling profiles. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
  import rsd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Number of random command transactions in each of the three idling phases.
  localparam int PHASE_ITEMS = 360;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Slowest command is a full dispatch scan over every entry.
  localparam int DRAIN_CYCLES = 24;

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int      mismatches;
  int      awaiting;
  int      quiet_cycles = 0;

  // Idle percentages for the sender and the receiver.
  int      send_gap_pct   = 0;
  int      recv_stall_pct = 0;

  item_t   directed_items[$];

  reservation_station_dispatch_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  rsd_checker station_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .awaiting     (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random. A new draw every cycle means stalls land
  // on every phase of the block's work, including mid-scan and on the cycle
  // a result appears.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** reservation_station_dispatch_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Operand values lean toward the all-zero and all-one extremes now and then.
  function automatic logic [VALUE_W-1:0] pick_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t write_cmd(input int slot, input bit used, input bit started,
                                      input bit rdy_a, input bit rdy_b, input int fu,
                                      input logic [VALUE_W-1:0] a,
                                      input logic [VALUE_W-1:0] b);
    item_t cmd;
    cmd                = '0;
    cmd.mode           = MODE_WRITE;
    cmd.entry          = ENTRY_W'(slot);
    cmd.entry_in_use   = used;
    cmd.entry_started  = started;
    cmd.ready_first    = rdy_a;
    cmd.ready_second   = rdy_b;
    cmd.unit           = UNIT_W'(fu);
    cmd.operand_first  = a;
    cmd.operand_second = b;
    cmd.unit_free      = 1'($urandom_range(1));
    return cmd;
  endfunction

  // Availability writes, dispatches and counter reads. The fields that these
  // modes ignore carry random noise so the block is seen to ignore them.
  function automatic item_t control_cmd(input mode_t m, input int fu, input bit free);
    item_t cmd;
    cmd                = '0;
    cmd.mode           = m;
    cmd.entry          = ENTRY_W'($urandom_range(7));
    cmd.entry_in_use   = 1'($urandom_range(1));
    cmd.entry_started  = 1'($urandom_range(1));
    cmd.ready_first    = 1'($urandom_range(1));
    cmd.ready_second   = 1'($urandom_range(1));
    cmd.unit           = UNIT_W'(fu);
    cmd.operand_first  = $urandom;
    cmd.operand_second = $urandom;
    cmd.unit_free      = free;
    return cmd;
  endfunction

  // Random traffic is weighted so that the table stays populated with ready
  // entries: most writes mark the entry in use and both operands ready, and
  // dispatch cycles are the most common command.
  function automatic item_t random_cmd();
    item_t cmd;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      cmd = write_cmd($urandom_range(7), $urandom_range(99) < 85,
                      $urandom_range(99) < 15, $urandom_range(99) < 75,
                      $urandom_range(99) < 75, $urandom_range(3),
                      pick_operand(), pick_operand());
    end else if (pick < 50) begin
      cmd = control_cmd(MODE_AVAIL, $urandom_range(3), $urandom_range(99) < 60);
    end else if (pick < 90) begin
      cmd = control_cmd(MODE_DISPATCH, $urandom_range(3), 1'($urandom_range(1)));
    end else begin
      cmd = control_cmd(MODE_READ, $urandom_range(3), 1'($urandom_range(1)));
    end
    return cmd;
  endfunction

  // Presents one command transaction and returns on the edge that accepts it.
  // The payload is held while the block stalls; valid is only dropped during
  // sender idle cycles that come before the transaction.
  task automatic send_cmd(input item_t cmd);
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= cmd;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++)
      send_cmd(random_cmd());
  endtask

  initial begin
    // Reset is held at the start and released on a clock edge.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence. After reset every unit is busy and the table empty.
    // A dispatch on an empty table gives an all-zero result.
    directed_items.push_back(control_cmd(MODE_DISPATCH, 0, 1'b0));
    // A ready entry on a busy unit stalls and bumps that unit's counter.
    directed_items.push_back(write_cmd(0, 1, 0, 1, 1, 0, '1, '0));
    directed_items.push_back(control_cmd(MODE_DISPATCH, 1, 1'b1));
    directed_items.push_back(control_cmd(MODE_READ, 0, 1'b0));
    // Freeing the unit lets the entry go; a second dispatch finds it started.
    directed_items.push_back(control_cmd(MODE_AVAIL, 0, 1'b1));
    directed_items.push_back(control_cmd(MODE_DISPATCH, 2, 1'b0));
    directed_items.push_back(control_cmd(MODE_DISPATCH, 3, 1'b1));
    // Entries that must be skipped: already started, one operand not ready,
    // and not in use at all.
    directed_items.push_back(write_cmd(7, 1, 1, 1, 1, 3, 32'h8000_0001, 32'h7FFF_FFFE));
    directed_items.push_back(write_cmd(5, 1, 0, 1, 0, 1, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
    directed_items.push_back(write_cmd(3, 0, 0, 1, 1, 2, 32'hDEAD_BEEF, 32'hCAFE_F00D));
    directed_items.push_back(write_cmd(4, 1, 0, 0, 1, 1, 32'h1, 32'h2));
    directed_items.push_back(write_cmd(6, 1, 0, 1, 1, 3, 32'hAAAA_AAAA, 32'h5555_5555));
    directed_items.push_back(write_cmd(2, 1, 0, 1, 1, 2, 32'h1234_5678, '1));
    // The scan starts past entry 0: entry 2 stalls on unit 2, entry 6 goes.
    directed_items.push_back(control_cmd(MODE_AVAIL, 3, 1'b1));
    directed_items.push_back(control_cmd(MODE_DISPATCH, 0, 1'b0));
    directed_items.push_back(control_cmd(MODE_AVAIL, 3, 1'b0));
    directed_items.push_back(control_cmd(MODE_AVAIL, 2, 1'b1));
    directed_items.push_back(control_cmd(MODE_DISPATCH, 1, 1'b1));
    directed_items.push_back(control_cmd(MODE_READ, 2, 1'b1));
    directed_items.push_back(control_cmd(MODE_READ, 3, 1'b0));
    directed_items.push_back(control_cmd(MODE_READ, 1, 1'b1));
    // Two entries on unit 1, one with all-ones operands; both dispatch in
    // scan order once unit 1 is free.
    directed_items.push_back(write_cmd(1, 1, 0, 1, 1, 1, '0, '0));
    directed_items.push_back(write_cmd(4, 1, 0, 1, 1, 1, '1, '1));
    directed_items.push_back(control_cmd(MODE_AVAIL, 1, 1'b1));
    directed_items.push_back(control_cmd(MODE_DISPATCH, 2, 1'b0));
    directed_items.push_back(control_cmd(MODE_DISPATCH, 3, 1'b1));

    // Phase one: sender idles often, receiver stalls more.
    send_gap_pct   = 32;
    recv_stall_pct = 47;
    foreach (directed_items[i])
      send_cmd(directed_items[i]);
    run_random(PHASE_ITEMS);

    // Phase two: the idling rates swap sides.
    send_gap_pct   = 47;
    recv_stall_pct = 32;
    run_random(PHASE_ITEMS);

    // Phase three: back-to-back traffic with no idling on either side.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
    item_valid <= 1'b0;

    // Wait for every predicted result, then give the block time to show any
    // stray result before the verdict. The watchdog bounds this wait.
    do @(negedge clk); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0 && awaiting == 0) begin
      $display("** reservation_station_dispatch_unit: PASSED **");
    end else begin
      $display("** reservation_station_dispatch_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rsd_pkg.sv
rtl/rsd_entry_mem.sv
rtl/rsd_stall_unit.sv
rtl/reservation_station_dispatch_unit.sv
verif/rsd_checker.sv
verif/tb_top.sv
